// ----- rtl/core/button_click_classifier_top_assert.svh -----
// Assertion macros for the button click classifier.
// Each expects clk and rst_n to be visible where it is used.
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication.
`define BCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bcc_pkg.sv -----
package bcc_pkg;

  localparam int LEVEL_W       = 6;
  localparam int TIME_W        = 32;
  localparam int MS_W          = 16;
  localparam int EVENTS_W      = 12;
  localparam int EV_W          = 2;
  localparam int EVENT_BUTTONS = EVENTS_W / EV_W;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int PS_W          = 3;
  localparam int DS_W          = 2;

  // Event codes
  localparam logic [EV_W-1:0] EV_IDLE   = 2'd0;
  localparam logic [EV_W-1:0] EV_CLICK  = 2'd1;
  localparam logic [EV_W-1:0] EV_LCLICK = 2'd2;

  // Press machine states
  localparam logic [PS_W-1:0] PS_IDLE          = 3'd0;
  localparam logic [PS_W-1:0] PS_PRESS_TRY     = 3'd1;
  localparam logic [PS_W-1:0] PS_PRESSED       = 3'd2;
  localparam logic [PS_W-1:0] PS_LPRESSED      = 3'd3;
  localparam logic [PS_W-1:0] PS_REL_TRY_SHORT = 3'd4;
  localparam logic [PS_W-1:0] PS_REL_TRY_LONG  = 3'd5;

  // Double-click tracker states (code 3 unused, held if ever seen)
  localparam logic [DS_W-1:0] DS_IDLE = 2'd0;
  localparam logic [DS_W-1:0] DS_CLK1 = 2'd1;
  localparam logic [DS_W-1:0] DS_CLK2 = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CLICK = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT      = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_EN   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LVL  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_MODE = 8'd7;

  // Register reset values
  localparam logic [MS_W-1:0] DEBOUNCE_RST    = 16'd20;
  localparam logic [MS_W-1:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic [MS_W-1:0] DOUBLE_GAP_RST  = 16'd300;
  localparam logic [MS_W-1:0] FIRST_CLICK_RST = 16'd300;
  localparam logic [MS_W-1:0] REPEAT_RST      = 16'd200;

  typedef struct packed {
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] long_press_ms;
    logic [MS_W-1:0] double_gap_ms;
    logic [MS_W-1:0] first_click_ms;
    logic [MS_W-1:0] repeat_ms;
    logic            repeat_enable;
    logic            press_level;
  } lane_cfg_t;

  typedef struct packed {
    logic            take;  // request accepted this cycle
    logic            clr;   // some lane changed: pending events move to snapshot
  } lane_ctl_t;

  typedef struct packed {
    logic            active;
    logic            restored;
    logic [EV_W-1:0] pending;  // pending event after this request
  } lane_stat_t;

  typedef struct packed {
    logic [EVENTS_W-1:0] events;
    logic                changed_active;
    logic                changed_restored;
    logic                notify;
    logic [TIME_W-1:0]   last_active_ms;
  } out_item_t;

endpackage

// ----- rtl/core/bcc_in_if.sv -----
interface bcc_in_if;
  import bcc_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] button_levels;
  logic [TIME_W-1:0]  now_ms;

  modport source (output valid, button_levels, now_ms, input ready);
  modport sink   (input valid, button_levels, now_ms, output ready);
endinterface

// ----- rtl/core/bcc_out_if.sv -----
interface bcc_out_if;
  import bcc_pkg::*;

  logic                valid;
  logic                ready;
  logic [EVENTS_W-1:0] events;
  logic                changed_active;
  logic                changed_restored;
  logic                notify;
  logic [TIME_W-1:0]   last_active_ms;

  modport source (output valid, events, changed_active, changed_restored, notify,
                  last_active_ms, input ready);
  modport sink   (input valid, events, changed_active, changed_restored, notify,
                  last_active_ms, output ready);
endinterface

// ----- rtl/core/bcc_cfg_if.sv -----
interface bcc_cfg_if;
  import bcc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/bcc_lane.sv -----
module bcc_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bcc_pkg::lane_cfg_t            cfg,
  input  bcc_pkg::lane_ctl_t            ctl,
  input  logic                          level,
  input  logic [bcc_pkg::TIME_W-1:0]    now_ms,
  output bcc_pkg::lane_stat_t           stat
);
  import bcc_pkg::*;

  logic [PS_W-1:0]   ps_r, ps_nxt;
  logic [DS_W-1:0]   ds_r, ds_nxt;
  logic [EV_W-1:0]   pend_r, pend_nxt;
  logic [TIME_W-1:0] edge_ts_r, edge_ts_nxt;
  logic [TIME_W-1:0] dbl_ts_r, dbl_ts_nxt;

  logic              pressed;
  logic [TIME_W-1:0] since_edge, since_dbl;
  logic              deb_done, long_done, rpt_done, gap_ok, first_ok;
  logic              act, rest;

  assign pressed    = (level == cfg.press_level);
  assign since_edge = now_ms - edge_ts_r;   // wraps mod 2^32
  assign since_dbl  = now_ms - dbl_ts_r;
  assign deb_done   = since_edge >= TIME_W'(cfg.debounce_ms);
  assign long_done  = since_edge >= TIME_W'(cfg.long_press_ms);
  assign rpt_done   = since_edge >= TIME_W'(cfg.repeat_ms);
  assign gap_ok     = since_dbl <= TIME_W'(cfg.double_gap_ms);
  assign first_ok   = since_dbl <= TIME_W'(cfg.first_click_ms);

  always_comb begin
    ps_nxt      = ps_r;
    ds_nxt      = ds_r;
    pend_nxt    = pend_r;
    edge_ts_nxt = edge_ts_r;
    dbl_ts_nxt  = dbl_ts_r;
    act         = 1'b0;
    rest        = 1'b0;
    unique case (ps_r)
      PS_IDLE: begin
        if (pressed) begin
          ps_nxt      = PS_PRESS_TRY;
          edge_ts_nxt = now_ms;
        end
        // first click expired without a second one
        if (ds_r == DS_CLK1 && !gap_ok) begin
          ds_nxt   = DS_IDLE;
          pend_nxt = EV_IDLE;
          rest     = 1'b1;
        end
      end
      PS_PRESS_TRY: begin
        if (deb_done) begin
          if (pressed) begin
            ps_nxt      = PS_PRESSED;
            pend_nxt    = EV_CLICK;
            edge_ts_nxt = now_ms;
            act         = 1'b1;
            if (ds_r == DS_IDLE) begin
              dbl_ts_nxt = now_ms;
            end else if (ds_r == DS_CLK1) begin
              if (gap_ok) begin
                ds_nxt     = DS_CLK2;
                dbl_ts_nxt = now_ms;
              end else begin
                ds_nxt = DS_IDLE;  // too late: keep old stamp
              end
            end else if (ds_r == DS_CLK2) begin
              ds_nxt = DS_IDLE;
            end
          end else begin
            ps_nxt = PS_IDLE;
          end
        end
      end
      PS_PRESSED: begin
        if (!pressed) begin
          ps_nxt      = PS_REL_TRY_SHORT;
          edge_ts_nxt = now_ms;
        end else if (long_done) begin
          ps_nxt      = PS_LPRESSED;
          edge_ts_nxt = now_ms;
          pend_nxt    = EV_LCLICK;
          act         = 1'b1;
        end
      end
      PS_LPRESSED: begin
        if (!pressed) begin
          ps_nxt      = PS_REL_TRY_LONG;
          edge_ts_nxt = now_ms;
        end else if (cfg.repeat_enable && rpt_done) begin
          edge_ts_nxt = now_ms;
          pend_nxt    = EV_CLICK;
          act         = 1'b1;
        end
      end
      PS_REL_TRY_SHORT, PS_REL_TRY_LONG: begin
        if (deb_done) begin
          if (!pressed) begin
            ps_nxt      = PS_IDLE;
            edge_ts_nxt = now_ms;
            if (ds_r == DS_IDLE) begin
              if (first_ok) begin
                ds_nxt     = DS_CLK1;
                dbl_ts_nxt = now_ms;
              end else begin
                pend_nxt = EV_IDLE;
                rest     = 1'b1;
              end
            end else if (ds_r == DS_CLK1 || ds_r == DS_CLK2) begin
              ds_nxt   = DS_IDLE;
              pend_nxt = EV_IDLE;
              rest     = 1'b1;
            end
          end else begin
            // bounce: return to the state the release started from
            ps_nxt = (ps_r == PS_REL_TRY_SHORT) ? PS_PRESSED : PS_LPRESSED;
          end
        end
      end
      default: begin
        ps_nxt = PS_IDLE;
      end
    endcase
  end

  assign stat.active   = act;
  assign stat.restored = rest;
  assign stat.pending  = pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r      <= PS_IDLE;
      ds_r      <= DS_IDLE;
      pend_r    <= EV_IDLE;
      edge_ts_r <= '0;
      dbl_ts_r  <= '0;
    end else if (ctl.take) begin
      ps_r      <= ps_nxt;
      ds_r      <= ds_nxt;
      pend_r    <= ctl.clr ? EV_IDLE : pend_nxt;
      edge_ts_r <= edge_ts_nxt;
      dbl_ts_r  <= dbl_ts_nxt;
    end
  end

endmodule

// ----- rtl/core/bcc_merge.sv -----
module bcc_merge #(
  parameter int BUTTONS = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bcc_pkg::lane_stat_t           stat [BUTTONS],
  input  logic                          take,
  input  logic [bcc_pkg::TIME_W-1:0]    now_ms,
  input  logic                          update_mode,
  output logic                          clr,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bcc_pkg::out_item_t            out_item
);
  import bcc_pkg::*;

  localparam int SNAP_N     = (BUTTONS < EVENT_BUTTONS) ? BUTTONS : EVENT_BUTTONS;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  logic [EVENTS_W-1:0] snap_r;
  logic [TIME_W-1:0]   activity_r;
  logic [EVENTS_W-1:0] snap_nxt;
  logic                any_act, any_rest;
  out_item_t           item;

  out_item_t           fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                pop;

  always_comb begin
    any_act  = 1'b0;
    any_rest = 1'b0;
    snap_nxt = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      any_act  = any_act | stat[i].active;
      any_rest = any_rest | stat[i].restored;
    end
    for (int i = 0; i < SNAP_N; i++) begin
      snap_nxt[EV_W*i +: EV_W] = stat[i].pending;
    end
  end

  assign clr = any_act | any_rest;

  always_comb begin
    item.events           = clr ? snap_nxt : snap_r;
    item.changed_active   = any_act;
    item.changed_restored = any_rest;
    item.notify           = any_act & ~update_mode;
    item.last_active_ms   = clr ? now_ms : activity_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_r     <= '0;
      activity_r <= '0;
    end else if (take && clr) begin
      snap_r     <= snap_nxt;
      activity_r <= now_ms;
    end
  end

  // two-entry output queue keeps intake open while one result waits
  assign in_ready  = (cnt_r != CNT_W'(FIFO_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & out_ready;
  assign out_item  = fifo_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (take) begin
      fifo_mem[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (take) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (take && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !take) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/button_click_classifier_top.sv -----
// Button click classifier. Each request carries one sample of all button pins
// and a millisecond time stamp; each request yields exactly one result with the
// event snapshot (2 bits per button: idle, click, long click), the active and
// restored change flags, notify (active change outside update mode) and the
// time stamp of the latest event change. One request is taken every clock
// cycle while the queue has room: every button has its own lane holding its
// debounce machine and double-click tracker, all lanes step in the same
// cycle as the request is accepted, and a merge stage ORs their change flags
// and builds the snapshot. The result is registered into a two-entry output
// queue behind earlier ones; in_chan.ready drops only while both entries are
// full. The longest path is one 32-bit subtract and compare per lane followed
// by the lane OR tree. All time differences wrap modulo 2^32. Configuration
// (register index 0..7, writes to other indexes are dropped) is always ready
// and must be written only while no request is in flight. Button i reads pin
// bit i; buttons 6 and up see a constant 0 and do not appear in events.
module button_click_classifier_top #(
  parameter int BUTTONS = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  bcc_in_if.sink    in_chan,
  bcc_out_if.source out_chan,
  bcc_cfg_if.sink   cfg_chan
);
  import bcc_pkg::*;

  // configuration registers
  logic [MS_W-1:0] debounce_r, long_press_r, double_gap_r, first_click_r, repeat_r;
  logic            repeat_en_r, active_lvl_r, update_mode_r;

  lane_cfg_t           lane_cfg;
  lane_ctl_t           lane_ctl;
  lane_stat_t          lane_stat [BUTTONS];
  logic [BUTTONS-1:0]  lane_lvl;
  logic                take;
  logic                clr;
  logic                in_ready;
  out_item_t           out_item;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= DEBOUNCE_RST;
      long_press_r  <= LONG_PRESS_RST;
      double_gap_r  <= DOUBLE_GAP_RST;
      first_click_r <= FIRST_CLICK_RST;
      repeat_r      <= REPEAT_RST;
      repeat_en_r   <= 1'b0;
      active_lvl_r  <= 1'b0;
      update_mode_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_DEBOUNCE:    debounce_r    <= cfg_chan.data;
        REG_LONG_PRESS:  long_press_r  <= cfg_chan.data;
        REG_DOUBLE_GAP:  double_gap_r  <= cfg_chan.data;
        REG_FIRST_CLICK: first_click_r <= cfg_chan.data;
        REG_REPEAT:      repeat_r      <= cfg_chan.data;
        REG_REPEAT_EN:   repeat_en_r   <= cfg_chan.data[0];
        REG_ACTIVE_LVL:  active_lvl_r  <= cfg_chan.data[0];
        REG_UPDATE_MODE: update_mode_r <= cfg_chan.data[0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  assign lane_cfg.debounce_ms    = debounce_r;
  assign lane_cfg.long_press_ms  = long_press_r;
  assign lane_cfg.double_gap_ms  = double_gap_r;
  assign lane_cfg.first_click_ms = first_click_r;
  assign lane_cfg.repeat_ms      = repeat_r;
  assign lane_cfg.repeat_enable  = repeat_en_r;
  assign lane_cfg.press_level    = active_lvl_r;

  // request handshake
  assign in_chan.ready = in_ready;
  assign take          = in_chan.valid & in_ready;
  assign lane_ctl.take = take;
  assign lane_ctl.clr  = clr;

  // one lane per button; buttons beyond the pin field read as 0
  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    if (i < LEVEL_W) begin : g_pin
      assign lane_lvl[i] = in_chan.button_levels[i];
    end else begin : g_nopin
      assign lane_lvl[i] = 1'b0;
    end

    bcc_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .cfg    (lane_cfg),
      .ctl    (lane_ctl),
      .level  (lane_lvl[i]),
      .now_ms (in_chan.now_ms),
      .stat   (lane_stat[i])
    );
  end

  bcc_merge #(
    .BUTTONS (BUTTONS)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .stat        (lane_stat),
    .take        (take),
    .now_ms      (in_chan.now_ms),
    .update_mode (update_mode_r),
    .clr         (clr),
    .in_ready    (in_ready),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_item    (out_item)
  );

  assign out_chan.events           = out_item.events;
  assign out_chan.changed_active   = out_item.changed_active;
  assign out_chan.changed_restored = out_item.changed_restored;
  assign out_chan.notify           = out_item.notify;
  assign out_chan.last_active_ms   = out_item.last_active_ms;

endmodule

// ----- rtl/core/bcc_checker.sv -----
`include "button_click_classifier_top_assert.svh"

module bcc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bcc_pkg::EVENTS_W-1:0]  events,
  input logic                          changed_active,
  input logic                          notify,
  input logic [bcc_pkg::TIME_W-1:0]    last_active_ms
);
  import bcc_pkg::*;

  // intake only closes when results are queued
  `BCC_ASSERT_NOW(a_stall_has_result, !in_ready, out_valid, "input stalled with empty output")

  // an accepted request into an idle output shows up next cycle
  `BCC_ASSERT_NEXT(a_result_follows, in_valid && in_ready && !out_valid, out_valid, "result missing after request")

  // notify is a subset of active changes
  `BCC_ASSERT_NOW(a_notify_active, out_valid && notify, changed_active, "notify without active change")

  // stalled result holds
  `BCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(events) && $stable(last_active_ms), "stalled result changed")

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .events         (out_chan.events),
  .changed_active (out_chan.changed_active),
  .notify         (out_chan.notify),
  .last_active_ms (out_chan.last_active_ms)
);

// ----- test/bcc_tb_pkg.sv -----
package bcc_tb_pkg;
  import bcc_pkg::*;

  // Lanes seen in the events field; the block is built with one lane per pin.
  localparam int LANES = EVENT_BUTTONS;

  // Tracks the click state of every button and keeps the results owed by the block.
  class click_scoreboard;
    logic [PS_W-1:0]     press_st [LANES];
    logic [DS_W-1:0]     dbl_st   [LANES];
    logic [EV_W-1:0]     pend_ev  [LANES];
    logic [TIME_W-1:0]   edge_ms  [LANES];
    logic [TIME_W-1:0]   dbl_ms   [LANES];
    logic [EVENTS_W-1:0] snap;
    logic [TIME_W-1:0]   last_ms;

    logic [MS_W-1:0] debounce, long_press, dbl_gap, first_click, rpt;
    bit              rpt_en, act_lvl, upd_mode;

    out_item_t owed_q[$];
    int        failures;

    function new();
      for (int b = 0; b < LANES; b++) begin
        press_st[b] = PS_IDLE;
        dbl_st[b]   = DS_IDLE;
        pend_ev[b]  = EV_IDLE;
        edge_ms[b]  = '0;
        dbl_ms[b]   = '0;
      end
      snap        = '0;
      last_ms     = '0;
      debounce    = DEBOUNCE_RST;
      long_press  = LONG_PRESS_RST;
      dbl_gap     = DOUBLE_GAP_RST;
      first_click = FIRST_CLICK_RST;
      rpt         = REPEAT_RST;
      rpt_en      = 1'b0;
      act_lvl     = 1'b0;
      upd_mode    = 1'b0;
      failures    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEBOUNCE:    debounce    = data;
        REG_LONG_PRESS:  long_press  = data;
        REG_DOUBLE_GAP:  dbl_gap     = data;
        REG_FIRST_CLICK: first_click = data;
        REG_REPEAT:      rpt         = data;
        REG_REPEAT_EN:   rpt_en      = data[0];
        REG_ACTIVE_LVL:  act_lvl     = data[0];
        REG_UPDATE_MODE: upd_mode    = data[0];
        default: ;
      endcase
    endfunction

    // One button, one sample. Raises act on a click or long click, rst on a return to idle.
    function void step_lane(int b, bit pressed, logic [TIME_W-1:0] now,
                            inout bit act, inout bit rst);
      logic [TIME_W-1:0] since_edge, since_dbl;
      since_edge = now - edge_ms[b];
      since_dbl  = now - dbl_ms[b];
      case (press_st[b])
        PS_IDLE: begin
          if (pressed) begin
            press_st[b] = PS_PRESS_TRY;
            edge_ms[b]  = now;
          end
          if (dbl_st[b] == DS_CLK1 && since_dbl > dbl_gap) begin
            dbl_st[b]  = DS_IDLE;
            pend_ev[b] = EV_IDLE;
            rst        = 1'b1;
          end
        end
        PS_PRESS_TRY: begin
          if (since_edge >= debounce) begin
            if (pressed) begin
              press_st[b] = PS_PRESSED;
              pend_ev[b]  = EV_CLICK;
              edge_ms[b]  = now;
              case (dbl_st[b])
                DS_IDLE: dbl_ms[b] = now;
                DS_CLK1: begin
                  if (since_dbl <= dbl_gap) begin
                    dbl_st[b] = DS_CLK2;
                    dbl_ms[b] = now;
                  end else begin
                    dbl_st[b] = DS_IDLE;  // second press too late, time stamp kept
                  end
                end
                DS_CLK2: dbl_st[b] = DS_IDLE;
                default: ;
              endcase
              act = 1'b1;
            end else begin
              press_st[b] = PS_IDLE;
            end
          end
        end
        PS_PRESSED: begin
          if (!pressed) begin
            press_st[b] = PS_REL_TRY_SHORT;
            edge_ms[b]  = now;
          end else if (since_edge >= long_press) begin
            press_st[b] = PS_LPRESSED;
            edge_ms[b]  = now;
            pend_ev[b]  = EV_LCLICK;
            act         = 1'b1;
          end
        end
        PS_LPRESSED: begin
          if (!pressed) begin
            press_st[b] = PS_REL_TRY_LONG;
            edge_ms[b]  = now;
          end else if (rpt_en && since_edge >= rpt) begin
            edge_ms[b] = now;
            pend_ev[b] = EV_CLICK;
            act        = 1'b1;
          end
        end
        PS_REL_TRY_SHORT, PS_REL_TRY_LONG: begin
          if (since_edge >= debounce) begin
            if (!pressed) begin
              press_st[b] = PS_IDLE;
              edge_ms[b]  = now;
              if (dbl_st[b] == DS_IDLE) begin
                if (since_dbl <= first_click) begin
                  dbl_st[b] = DS_CLK1;
                  dbl_ms[b] = now;
                end else begin
                  pend_ev[b] = EV_IDLE;
                  rst        = 1'b1;
                end
              end else if (dbl_st[b] == DS_CLK1 || dbl_st[b] == DS_CLK2) begin
                dbl_st[b]  = DS_IDLE;
                pend_ev[b] = EV_IDLE;
                rst        = 1'b1;
              end
            end else begin
              // bounce: back to where the release attempt started, edge time kept
              press_st[b] = (press_st[b] == PS_REL_TRY_SHORT) ? PS_PRESSED : PS_LPRESSED;
            end
          end
        end
        default: press_st[b] = PS_IDLE;
      endcase
    endfunction

    function void note_request(logic [LEVEL_W-1:0] pins, logic [TIME_W-1:0] now);
      bit        act, rst;
      out_item_t owed;
      act = 1'b0;
      rst = 1'b0;
      for (int b = 0; b < LANES; b++)
        step_lane(b, pins[b] == act_lvl, now, act, rst);
      if (act || rst) begin
        for (int b = 0; b < LANES; b++) begin
          snap[EV_W*b +: EV_W] = pend_ev[b];
          pend_ev[b] = EV_IDLE;
        end
        last_ms = now;
      end
      owed.events           = snap;
      owed.changed_active   = act;
      owed.changed_restored = rst;
      owed.notify           = act && !upd_mode;
      owed.last_active_ms   = last_ms;
      owed_q.push_back(owed);
    endfunction

    function void compare(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
        return;
      end
      want = owed_q.pop_front();
      compare("events", want.events, got.events);
      compare("changed_active", want.changed_active, got.changed_active);
      compare("changed_restored", want.changed_restored, got.changed_restored);
      compare("notify", want.notify, got.notify);
      compare("last_active_ms", want.last_active_ms, got.last_active_ms);
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

endpackage

// ----- test/tb_button_click_classifier_top.sv -----
module tb_button_click_classifier_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcc_pkg::*;
  import bcc_tb_pkg::*;

  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  // Random requests per configuration phase; six phases make about 2000.
  localparam int PHASE_REQS  = 330;

  logic clk = 1'b0;
  logic rst_n;

  always #6ns clk = ~clk;

  bcc_in_if  in_chan();
  bcc_out_if out_chan();
  bcc_cfg_if cfg_chan();

  button_click_classifier_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  click_scoreboard sb = new();

  // Percent of cycles in which the sender / receiver holds off.
  int in_idle_pct;
  int out_idle_pct;

  // Stimulus state: current time stamp, pin level that means pressed, and a
  // per-button hold model (intended position plus samples left in it).
  logic [TIME_W-1:0] clock_ms;
  bit                cur_act;
  int                step_hi;
  bit                held_dn   [LANES];
  int                hold_left [LANES];

  int stall_cnt;

  // Receiver: ready toggles at random at the configured hold-off rate.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Result checking and hang watchdog. Values read here are those in place
  // at the edge, since the block updates its outputs with nonblocking writes.
  always @(posedge clk) begin : result_mon
    out_item_t got;
    if (!rst_n) begin
      stall_cnt <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.events           = out_chan.events;
        got.changed_active   = out_chan.changed_active;
        got.changed_restored = out_chan.changed_restored;
        got.notify           = out_chan.notify;
        got.last_active_ms   = out_chan.last_active_ms;
        sb.check_result(got);
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // One request. Valid stays high from one request to the next unless the
  // sender decides to idle, so it is never lowered and raised in one step.
  task automatic send_sample(input logic [LEVEL_W-1:0] pins, input logic [TIME_W-1:0] now);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_chan.valid         <= 1'b1;
    in_chan.button_levels <= pins;
    in_chan.now_ms        <= now;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request(pins, now);
  endtask

  // Wait until every owed result is back, then let the output queue settle
  // before touching registers.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all eight registers, then one write to an unused index that must
  // be dropped. One-bit registers get junk in the upper data bits.
  task automatic configure(input logic [MS_W-1:0] deb, lng, gap, first, rpt,
                           input bit en, act, upd);
    logic [CFG_DATA_W-1:0] val [REG_UPDATE_MODE+1];
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_DATA_W-1:0] data;
    val[REG_DEBOUNCE]    = deb;
    val[REG_LONG_PRESS]  = lng;
    val[REG_DOUBLE_GAP]  = gap;
    val[REG_FIRST_CLICK] = first;
    val[REG_REPEAT]      = rpt;
    val[REG_REPEAT_EN]   = en;
    val[REG_ACTIVE_LVL]  = act;
    val[REG_UPDATE_MODE] = upd;
    cfg_chan.valid <= 1'b1;
    for (int i = REG_DEBOUNCE; i <= REG_UPDATE_MODE + 1; i++) begin
      junk = CFG_DATA_W'($urandom);
      if (i > REG_UPDATE_MODE) begin
        cfg_chan.index <= CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_UPDATE_MODE + 1));
        data = junk;
      end else if (i >= REG_REPEAT_EN) begin
        cfg_chan.index <= CFG_IDX_W'(i);
        data = {junk[CFG_DATA_W-1:1], val[i][0]};
      end else begin
        cfg_chan.index <= CFG_IDX_W'(i);
        data = val[i];
      end
      cfg_chan.data <= data;
      do @(posedge clk); while (!cfg_chan.ready);
      sb.write_reg(cfg_chan.index, data);
    end
    cfg_chan.valid <= 1'b0;
    cur_act = act;
    // time step scaled so that the longest window spans a handful of samples
    step_hi = ((lng > gap) ? ((lng > deb) ? lng : deb) : ((gap > deb) ? gap : deb)) / 4 + 2;
  endtask

  // Directed part, reset configuration (pressed = pin low, debounce 20,
  // long press 1000, windows 300): click, double click with a bounce on
  // release, long press, a second press that comes too late, time wrap.
  task automatic run_directed();
    logic [LEVEL_W-1:0] pins [24] = '{
      6'h3F, 6'h00, 6'h00, 6'h3F, 6'h3F, 6'h00, 6'h00, 6'h3F,
      6'h00, 6'h00, 6'h00, 6'h3F, 6'h00, 6'h3F, 6'h3E, 6'h3E,
      6'h3F, 6'h3F, 6'h3E, 6'h3E, 6'h15, 6'h15, 6'h2A, 6'h00};
    logic [TIME_W-1:0] stamp [24] = '{
      32'd0,    32'd5,    32'd30,   32'd60,   32'd85,   32'd100,  32'd125,  32'd140,
      32'd150,  32'd165,  32'd1200, 32'd1210, 32'd1215, 32'd1240, 32'd2000, 32'd2030,
      32'd2040, 32'd2070, 32'd2300, 32'd2380, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
      32'h0000_0010, 32'h0000_0030};
    for (int n = 0; n < 24; n++)
      send_sample(pins[n], stamp[n]);
  endtask

  // Random part: each button holds a position for a random number of
  // samples (short clicks, double clicks, long presses), with bounce on
  // single samples, occasional fully random pins, and time jumps that
  // sometimes cover the whole 32-bit range.
  task automatic run_random(input int count);
    logic [LEVEL_W-1:0] pins;
    bit                 down;
    int                 pick;
    clock_ms = $urandom;
    for (int n = 0; n < count; n++) begin
      for (int b = 0; b < LANES; b++) begin
        if (hold_left[b] == 0) begin
          held_dn[b]   = !held_dn[b];
          hold_left[b] = $urandom_range(1, 12);
        end
        hold_left[b]--;
        down    = held_dn[b] ^ ($urandom_range(0, 11) == 0);
        pins[b] = down ? cur_act : !cur_act;
      end
      if ($urandom_range(0, 99) < 3)
        pins = LEVEL_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 5)
        clock_ms = $urandom;
      else if (pick < 30)
        clock_ms += $urandom_range(0, 3 * step_hi);
      else
        clock_ms += $urandom_range(0, step_hi);
      send_sample(pins, clock_ms);
    end
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.button_levels <= '0;
    in_chan.now_ms        <= '0;
    cfg_chan.valid        <= 1'b0;
    cfg_chan.index        <= '0;
    cfg_chan.data         <= '0;
    cur_act   = 1'b0;
    step_hi   = 8;
    for (int b = 0; b < LANES; b++) begin
      held_dn[b]   = 1'b0;
      hold_left[b] = 0;
    end
    // sender idles a little, receiver a lot
    in_idle_pct  = 37;
    out_idle_pct = 78;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // short windows, repeat on
    settle();
    configure(16'd3, 16'd25, 16'd15, 16'd12, 16'd6, 1'b1, 1'b0, 1'b0);
    run_random(PHASE_REQS);

    // every interval zero, active high, update mode
    settle();
    configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1);
    run_random(PHASE_REQS);

    // roles swapped: sender idles a lot, receiver a little
    in_idle_pct  = 78;
    out_idle_pct = 37;

    // every interval at its maximum
    settle();
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
    run_random(PHASE_REQS);

    settle();
    configure(MS_W'($urandom_range(0, 8)), MS_W'($urandom_range(0, 60)),
              MS_W'($urandom_range(0, 40)), MS_W'($urandom_range(0, 40)),
              MS_W'($urandom_range(0, 10)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    run_random(PHASE_REQS);

    // no idling on either side
    in_idle_pct  = 0;
    out_idle_pct = 0;

    settle();
    configure(16'd2, 16'd40, 16'd30, 16'd30, 16'd3, 1'b1, 1'b0, 1'b1);
    run_random(PHASE_REQS);

    settle();
    configure(MS_W'($urandom_range(0, 8)), MS_W'($urandom_range(0, 60)),
              MS_W'($urandom_range(0, 40)), MS_W'($urandom_range(0, 40)),
              MS_W'($urandom_range(0, 10)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    run_random(PHASE_REQS);

    // drain; the watchdog covers a block that stops answering
    settle();
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
